FILE: design/captive_dns_responder_core_macros.svh
// Assertion macros used by the responder checker.
`ifndef CAPTIVE_DNS_RESPONDER_CORE_MACROS_SVH
`define CAPTIVE_DNS_RESPONDER_CORE_MACROS_SVH

// Same-cycle implication.
`define CDR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("responder check failed");

// Next-cycle implication.
`define CDR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("responder check failed");

`endif

FILE: design/cdr_pkg.sv
// Types, constants and tables shared by the captive DNS responder modules.
`default_nettype none
package cdr_pkg;

   localparam int MAX_DATAGRAM = 496;
   localparam int MAX_LABEL    = 63;

   localparam int POS_W = $clog2(MAX_DATAGRAM + 1);
   localparam int NLP_W = $clog2(MAX_DATAGRAM + MAX_LABEL + 1);

   localparam logic [POS_W-1:0] POS_FLAGS_HI   = POS_W'(2);
   localparam logic [POS_W-1:0] POS_FLAGS_LO   = POS_W'(3);
   localparam logic [POS_W-1:0] POS_QDCOUNT_HI = POS_W'(4);
   localparam logic [POS_W-1:0] POS_QDCOUNT_LO = POS_W'(5);
   localparam logic [POS_W-1:0] POS_ANCOUNT_HI = POS_W'(6);
   localparam logic [POS_W-1:0] POS_ANCOUNT_LO = POS_W'(7);
   localparam logic [POS_W-1:0] POS_NSCOUNT_HI = POS_W'(8);
   localparam logic [POS_W-1:0] POS_NSCOUNT_LO = POS_W'(9);
   localparam logic [POS_W-1:0] POS_ARCOUNT_HI = POS_W'(10);
   localparam logic [POS_W-1:0] POS_HEADER_END = POS_W'(11);
   localparam logic [NLP_W-1:0] FIRST_LABEL    = NLP_W'(12);

   localparam logic [7:0] RESP_FLAGS_HI = 8'h81;
   localparam logic [7:0] RESP_FLAGS_LO = 8'h80;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_ENABLE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_ADDRESS = 1'b1;
   localparam logic [31:0] ANSWER_ADDRESS_RESET = 32'hC0A8_0401;

   localparam int ANSWER_LEN  = 16;
   localparam int ANSWER_CNT_W = $clog2(ANSWER_LEN + 1);
   localparam int ANSWER_IDX_W = $clog2(ANSWER_LEN);
   localparam int PREFIX_LEN = 12;
   localparam logic [7:0] ANSWER_PREFIX [PREFIX_LEN] = '{
      8'hC0, 8'h0C, 8'h00, 8'h01, 8'h00, 8'h01,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h04
   };

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_NAME,
      PH_TYPECLASS
   } parse_phase_type;

   typedef struct packed {
      logic       emit;
      logic       drop;
      logic       done;
      logic [7:0] reply_byte;
   } parse_result_type;

endpackage
`default_nettype wire

FILE: design/cdr_req_if.sv
// Request channel: query bytes with a packet end flag.
`default_nettype none
interface cdr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_packet;

   modport source (output valid, output data_byte, output end_of_packet, input ready);
   modport sink (input valid, input data_byte, input end_of_packet, output ready);
endinterface
`default_nettype wire

FILE: design/cdr_rsp_if.sv
// Response channel: reply bytes with last and discard flags.
`default_nettype none
interface cdr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] reply_byte;
   logic       reply_last;
   logic       discard;

   modport source (output valid, output reply_byte, output reply_last, output discard,
                   input ready);
   modport sink (input valid, input reply_byte, input reply_last, input discard,
                 output ready);
endinterface
`default_nettype wire

FILE: design/cdr_parser.sv
// Query parser: header checks, label walk, type/class check and rewrite.
`default_nettype none
module cdr_parser import cdr_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             take,
   input  wire logic             enable,
   input  wire logic [7:0]       data_byte,
   input  wire logic             end_of_packet,
   output parse_result_type      result
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [NLP_W-1:0] nlp_ff, nlp_in;
   parse_phase_type  phase_ff, phase_in;
   logic [1:0]       tc_ff, tc_in;
   logic             fin_ff, fin_in;
   logic             fail, done, emit;
   logic [7:0]       ob;

   always_comb begin
      pos_in   = pos_ff;
      nlp_in   = nlp_ff;
      phase_in = phase_ff;
      tc_in    = tc_ff;
      fin_in   = fin_ff;
      fail     = 1'b0;
      done     = 1'b0;
      emit     = 1'b1;
      ob       = data_byte;
      if (fin_ff) begin
         // skip trailing bytes until the packet ends
         emit = 1'b0;
      end else begin
         if (!enable || pos_ff >= POS_W'(MAX_DATAGRAM)) begin
            fail = 1'b1;
         end else begin
            unique case (phase_ff)
               PH_HEADER: begin
                  unique case (pos_ff)
                     POS_FLAGS_HI: begin
                        fail = data_byte[7];
                        ob   = RESP_FLAGS_HI;
                     end
                     POS_FLAGS_LO:   ob = RESP_FLAGS_LO;
                     POS_QDCOUNT_HI: fail = (data_byte != 8'd0);
                     POS_QDCOUNT_LO: fail = (data_byte != 8'd1);
                     POS_ANCOUNT_HI: ob = 8'd0;
                     POS_ANCOUNT_LO: ob = 8'd1;
                     POS_NSCOUNT_HI, POS_NSCOUNT_LO,
                     POS_ARCOUNT_HI, POS_HEADER_END: ob = 8'd0;
                     default: ;
                  endcase
                  if (pos_ff == POS_HEADER_END) begin
                     phase_in = PH_NAME;
                  end
               end
               PH_NAME: begin
                  if (NLP_W'(pos_ff) == nlp_ff) begin
                     if (data_byte == 8'd0) begin
                        phase_in = PH_TYPECLASS;
                     end else if (data_byte > 8'(MAX_LABEL)) begin
                        fail = 1'b1;
                     end else begin
                        nlp_in = NLP_W'(pos_ff) + NLP_W'(data_byte) + NLP_W'(1);
                     end
                  end
               end
               PH_TYPECLASS: begin
                  if (data_byte != {7'd0, tc_ff[0]}) begin
                     fail = 1'b1;
                  end else if (tc_ff == 2'd3) begin
                     done = 1'b1;
                  end else begin
                     tc_in = tc_ff + 2'd1;
                  end
               end
               default: fail = 1'b1;
            endcase
         end
         if (!fail && !done && end_of_packet) begin
            fail = 1'b1;
         end
         if (!fail) begin
            pos_in = pos_ff + POS_W'(1);
         end
         if (fail || done) begin
            fin_in = 1'b1;
         end
      end
      // return to the idle packet state on the final byte
      if (end_of_packet) begin
         pos_in   = '0;
         nlp_in   = FIRST_LABEL;
         phase_in = PH_HEADER;
         tc_in    = 2'd0;
         fin_in   = 1'b0;
      end
   end

   assign result.emit       = emit;
   assign result.drop       = fail;
   assign result.done       = done;
   assign result.reply_byte = fail ? 8'd0 : ob;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         nlp_ff   <= FIRST_LABEL;
         phase_ff <= PH_HEADER;
         tc_ff    <= 2'd0;
         fin_ff   <= 1'b0;
      end else if (take) begin
         pos_ff   <= pos_in;
         nlp_ff   <= nlp_in;
         phase_ff <= phase_in;
         tc_ff    <= tc_in;
         fin_ff   <= fin_in;
      end
   end

endmodule
`default_nettype wire

FILE: design/cdr_answer.sv
// Output register and answer record sequencer.
`default_nettype none
module cdr_answer import cdr_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire parse_result_type result,
   input  wire logic [31:0]      address,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [7:0]            reply_byte,
   output logic                  reply_last,
   output logic                  discard
);

   logic                    valid_ff, valid_in;
   logic [7:0]              byte_ff, byte_in;
   logic                    last_ff, last_in;
   logic                    disc_ff, disc_in;
   logic [ANSWER_CNT_W-1:0] cnt_ff, cnt_in;
   logic [ANSWER_IDX_W-1:0] idx;
   logic [7:0]              answer_byte;
   logic                    out_free;
   logic                    take;

   assign out_free  = !valid_ff || rsp_ready;
   assign req_ready = out_free && (cnt_ff == '0);
   assign take      = req_valid && req_ready;

   // answer byte index counts up as the remaining count drains
   assign idx = ANSWER_IDX_W'(ANSWER_CNT_W'(ANSWER_LEN) - cnt_ff);

   always_comb begin
      if (idx < ANSWER_IDX_W'(PREFIX_LEN)) begin
         answer_byte = ANSWER_PREFIX[idx];
      end else begin
         unique case (idx[1:0])
            2'd0:    answer_byte = address[31:24];
            2'd1:    answer_byte = address[23:16];
            2'd2:    answer_byte = address[15:8];
            default: answer_byte = address[7:0];
         endcase
      end
   end

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      disc_in  = disc_ff;
      cnt_in   = cnt_ff;
      if (out_free) begin
         if (cnt_ff != '0) begin
            valid_in = 1'b1;
            byte_in  = answer_byte;
            last_in  = (cnt_ff == ANSWER_CNT_W'(1));
            disc_in  = 1'b0;
            cnt_in   = cnt_ff - ANSWER_CNT_W'(1);
         end else if (take && result.emit) begin
            valid_in = 1'b1;
            byte_in  = result.reply_byte;
            last_in  = result.drop;
            disc_in  = result.drop;
            if (result.done) begin
               cnt_in = ANSWER_CNT_W'(ANSWER_LEN);
            end
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      disc_ff <= disc_in;
   end

   assign rsp_valid  = valid_ff;
   assign reply_byte = byte_ff;
   assign reply_last = last_ff;
   assign discard    = disc_ff;

endmodule
`default_nettype wire

FILE: design/captive_dns_responder_core.sv
// Captive portal DNS responder: top level with configuration registers.
//
// Usage:
//   req_chan carries one query byte per request (data_byte, end_of_packet on
//   the final byte). rsp_chan returns the response stream: header and question
//   bytes as they pass, with flags rewritten to 81 80 and counts to 1/1/0/0,
//   then a 16-byte A record holding answer_address after the last class byte.
//   A failed query yields one drop marker (reply_byte 0, reply_last and discard
//   set); the receiver throws away every byte it already took for that packet.
//   Output: a request's reply byte is registered and shows on rsp_chan in the
//   cycle after accept. Throughput: one request per cycle while the output is
//   not stalled; after the final class byte the answer sequencer owns the
//   output register for the A record and req_chan.ready stays low meanwhile.
//   Stall: rsp_chan.ready low while a reply is offered holds the output
//   register and drops req_chan.ready; no byte is lost or repeated.
//   Reset (synchronous, active high): the parser returns to the header,
//   the output empties, responder_enable clears and answer_address returns
//   to 192.168.4.1. Write csr_* only while the block is idle.
`default_nettype none
module captive_dns_responder_core import cdr_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   cdr_req_if.sink                   req_chan,
   cdr_rsp_if.source                 rsp_chan,
   input  wire logic                 csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]          csr_write_data
);

   logic             enable_ff;
   logic [31:0]      address_ff;
   logic             take;
   parse_result_type result;

   // configuration registers: write only, no read-back
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b0;
         address_ff <= ANSWER_ADDRESS_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_IDX_ENABLE:  enable_ff  <= csr_write_data[0];
            CSR_IDX_ADDRESS: address_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // advance the parser on every accepted request
   assign take = req_chan.valid && req_chan.ready;

   cdr_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .take          (take),
      .enable        (enable_ff),
      .data_byte     (req_chan.data_byte),
      .end_of_packet (req_chan.end_of_packet),
      .result        (result)
   );

   // hold the reply in the output register, append the answer after it
   cdr_answer u_answer (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_ready  (req_chan.ready),
      .result     (result),
      .address    (address_ff),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .reply_byte (rsp_chan.reply_byte),
      .reply_last (rsp_chan.reply_last),
      .discard    (rsp_chan.discard)
   );

endmodule
`default_nettype wire

FILE: design/cdr_checker.sv
// Port-level checker for the responder and its bind.
`default_nettype none
`include "captive_dns_responder_core_macros.svh"
module cdr_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] reply_byte,
   input wire logic       reply_last,
   input wire logic       discard
);

   // a drop marker is a single zero byte that closes the packet
   `CDR_ASSERT_IMPLY(a_drop_marker, clock, reset, rsp_valid && discard, reply_last && reply_byte == 8'h00)
   // a stalled reply holds
   `CDR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(reply_byte) && $stable(reply_last) && $stable(discard))
   // a stalled output blocks new requests
   `CDR_ASSERT_IMPLY(a_stall_blocks, clock, reset, rsp_valid && !rsp_ready, !req_ready)
   // reset empties the output
   `CDR_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind captive_dns_responder_core cdr_checker u_cdr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .reply_byte (rsp_chan.reply_byte),
   .reply_last (rsp_chan.reply_last),
   .discard    (rsp_chan.discard)
);
`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking testbench for the captive DNS responder core.
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import cdr_pkg::*;

   // Cycles without any handshake before the run is declared hung. The
   // longest legal quiet stretch is an idle pause plus two register writes
   // plus one full wait on each side.
   localparam int STALL_LIMIT = 2000;
   // Settle time after the last expected reply, so a stray reply is still caught.
   localparam int SETTLE_CYCLES = 20;

   typedef struct packed {
      logic [7:0] reply_byte;
      logic       reply_last;
      logic       discard;
   } dns_reply_type;

   // Fixed part of the A record: name pointer, type, class, TTL, length.
   localparam logic [7:0] A_RECORD_HEAD [12] = '{
      8'hC0, 8'h0C, 8'h00, 8'h01, 8'h00, 8'h01,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h04
   };

   // Predicts the reply stream of each query byte and checks the replies in order.
   class dns_reply_ledger;
      logic             enable;
      logic [31:0]      address;
      logic [POS_W-1:0] position;
      logic [NLP_W-1:0] label_position;
      parse_phase_type  phase;
      logic [1:0]       type_class_seen;
      logic             skipping;
      dns_reply_type    expected_replies[$];
      int unsigned      errors;

      function new();
         enable  = 1'b0;
         address = 32'hC0A8_0401;
         errors  = 0;
         restart();
      endfunction

      function void restart();
         position        = '0;
         label_position  = NLP_W'(12);
         phase           = PH_HEADER;
         type_class_seen = '0;
         skipping        = 1'b0;
      endfunction

      function void expect_reply(logic [7:0] value, logic last, logic drop);
         expected_replies.push_back({value, last, drop});
      endfunction

      function void predict_reply(logic [7:0] data, logic eop);
         logic       drop;
         logic       answer;
         logic [7:0] echo;
         drop   = 1'b0;
         answer = 1'b0;
         echo   = data;
         if (skipping) begin
            if (eop) restart();
            return;
         end
         if (!enable || position >= MAX_DATAGRAM) begin
            drop = 1'b1;
         end else begin
            case (phase)
               PH_HEADER: begin
                  // Flags become a response, counts become 1/1/0/0.
                  case (position)
                     2: begin
                        drop = data[7];
                        echo = 8'h81;
                     end
                     3: echo = 8'h80;
                     4: drop = (data != 8'h00);
                     5: drop = (data != 8'h01);
                     7: echo = 8'h01;
                     6, 8, 9, 10, 11: echo = 8'h00;
                     default: ;
                  endcase
                  if (position == 11) phase = PH_NAME;
               end
               PH_NAME: begin
                  if (position == label_position) begin
                     if (data == 8'h00) phase = PH_TYPECLASS;
                     else if (data > MAX_LABEL) drop = 1'b1;
                     else label_position = NLP_W'(int'(position) + 1 + int'(data));
                  end
               end
               default: begin
                  // Type and class alternate high byte 00, low byte 01.
                  if (data != {7'd0, type_class_seen[0]}) drop = 1'b1;
                  else if (type_class_seen == 2'd3) answer = 1'b1;
                  else type_class_seen++;
               end
            endcase
         end
         if (!drop && !answer && eop) drop = 1'b1;
         if (drop) begin
            expect_reply(8'h00, 1'b1, 1'b1);
            if (eop) restart();
            else skipping = 1'b1;
            return;
         end
         expect_reply(echo, 1'b0, 1'b0);
         position++;
         if (answer) begin
            for (int i = 0; i < 12; i++) expect_reply(A_RECORD_HEAD[i], 1'b0, 1'b0);
            for (int i = 3; i >= 0; i--) expect_reply(address[8*i +: 8], i == 0, 1'b0);
            if (eop) restart();
            else skipping = 1'b1;
         end
      endfunction

      function void report(string field, logic [7:0] want, logic [7:0] got);
         errors++;
         $display("%0t: %s mismatch, expected %02h, actual %02h", $time, field, want, got);
      endfunction

      function void compare_reply(dns_reply_type got);
         dns_reply_type want;
         if (expected_replies.size() == 0) begin
            errors++;
            $display("%0t: reply with none expected, actual byte %02h last %0b discard %0b",
                     $time, got.reply_byte, got.reply_last, got.discard);
            return;
         end
         want = expected_replies.pop_front();
         if (got.reply_byte !== want.reply_byte)
            report("reply_byte", want.reply_byte, got.reply_byte);
         if (got.reply_last !== want.reply_last)
            report("reply_last", 8'(want.reply_last), 8'(got.reply_last));
         if (got.discard !== want.discard)
            report("discard", 8'(want.discard), 8'(got.discard));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0]          csr_write_data;

   cdr_req_if req_chan ();
   cdr_rsp_if rsp_chan ();

   captive_dns_responder_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   dns_reply_ledger ledger;

   logic [7:0]  query_bytes[$];     // packet under construction
   logic [8:0]  request_stream[$];  // {end_of_packet, data_byte} awaiting the driver
   int unsigned pushed_count   = 0;
   int unsigned accepted_count = 0;
   logic        req_taken      = 1'b0;
   int unsigned req_gap        = 0;
   int unsigned reply_wait     = 0;
   int unsigned quiet_cycles   = 0;
   // Each side switches at random between stretches of random waits and stretches
   // with none, so back-to-back traffic and stalls both land on every phase.
   int unsigned req_left  = 0;
   int unsigned rsp_left  = 0;
   bit          req_calm  = 1'b0;
   bit          rsp_calm  = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Assert reset at start-up, then release it for good.
   initial begin
      repeat (6) @(negedge clock);
      reset = 1'b0;
   end

   function automatic int unsigned draw_wait(inout int unsigned left, inout bit calm);
      if (left == 0) begin
         calm = ($urandom_range(0, 2) == 0);
         left = $urandom_range(10, 60);
      end
      left--;
      return calm ? 0 : $urandom_range(0, 14);
   endfunction

   // Request driver: on each falling edge, once the current request has been
   // taken, idle for the drawn gap, then present the next request.
   initial begin
      req_chan.valid         = 1'b0;
      req_chan.data_byte     = 8'h00;
      req_chan.end_of_packet = 1'b0;
      forever begin
         @(negedge clock);
         if (!reset && (!req_chan.valid || req_taken)) begin
            if (req_gap > 0) begin
               req_chan.valid <= 1'b0;
               req_gap--;
            end else if (request_stream.size() != 0) begin
               {req_chan.end_of_packet, req_chan.data_byte} <= request_stream.pop_front();
               req_chan.valid <= 1'b1;
               req_gap = draw_wait(req_left, req_calm);
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Reply side: drop ready for the drawn number of cycles while a reply is
   // offered, then take it.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!reset) begin
            if (reply_wait > 0) begin
               rsp_chan.ready <= 1'b0;
               if (rsp_chan.valid) reply_wait--;
            end else begin
               rsp_chan.ready <= 1'b1;
            end
         end
      end
   end

   // Sample both handshakes on the rising edge; predict first, since a reply
   // always belongs to a request accepted on an earlier edge.
   always @(posedge clock) begin
      if (!reset) begin
         req_taken = req_chan.valid && req_chan.ready;
         if (req_taken) begin
            ledger.predict_reply(req_chan.data_byte, req_chan.end_of_packet);
            accepted_count++;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            ledger.compare_reply({rsp_chan.reply_byte, rsp_chan.reply_last, rsp_chan.discard});
            reply_wait = draw_wait(rsp_left, rsp_calm);
            quiet_cycles = 0;
         end else if (req_taken) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
               $display("%0t: no handshake for %0d cycles, %0d replies outstanding",
                        $time, quiet_cycles, ledger.expected_replies.size());
               $display("Test completed with failures");
               $finish;
            end
         end
      end
   end

   // Block until every queued request is taken and every reply has arrived,
   // then wait out the settle time so that any stray reply is still caught.
   task automatic wait_quiet();
      while (accepted_count != pushed_count || ledger.expected_replies.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_IDX_ENABLE) ledger.enable = value[0];
      else ledger.address = value;
   endtask

   // Hand the packet to the driver, end_of_packet on its final byte.
   task automatic queue_packet();
      foreach (query_bytes[i]) begin
         request_stream.push_back({(i == query_bytes.size() - 1) ? 1'b1 : 1'b0,
                                   query_bytes[i]});
         pushed_count++;
      end
   endtask

   // Header with random id, flags and counts, except a clear response bit
   // and exactly one question.
   function automatic void start_query();
      query_bytes.delete();
      query_bytes.push_back(8'($urandom));
      query_bytes.push_back(8'($urandom));
      query_bytes.push_back(8'($urandom_range(0, 127)));
      query_bytes.push_back(8'($urandom));
      query_bytes.push_back(8'h00);
      query_bytes.push_back(8'h01);
      repeat (6) query_bytes.push_back(8'($urandom));
   endfunction

   function automatic void add_label(int unsigned len);
      query_bytes.push_back(8'(len));
      repeat (len) query_bytes.push_back(8'($urandom));
   endfunction

   // Root terminator, then type A and class IN.
   function automatic void end_query();
      query_bytes.push_back(8'h00);
      query_bytes.push_back(8'h00);
      query_bytes.push_back(8'h01);
      query_bytes.push_back(8'h00);
      query_bytes.push_back(8'h01);
   endfunction

   // Mostly well-formed queries; the rest are line noise or each break one rule.
   function automatic void random_query();
      int unsigned kind;
      int unsigned spot;
      int unsigned cut;
      kind = $urandom_range(0, 99);
      if (kind >= 92) begin
         // Line noise.
         query_bytes.delete();
         repeat ($urandom_range(1, 20)) query_bytes.push_back(8'($urandom));
         return;
      end
      start_query();
      repeat ($urandom_range(1, 3))
         add_label(($urandom_range(0, 7) == 0) ? MAX_LABEL : $urandom_range(1, 12));
      end_query();
      if (kind < 55) begin
         // Trailing bytes after the question are skipped.
         repeat ($urandom_range(0, 3)) query_bytes.push_back(8'($urandom));
      end else if (kind < 62) begin
         query_bytes[2][7] = 1'b1;
      end else if (kind < 69) begin
         if ($urandom_range(0, 1) != 0) query_bytes[4] = 8'($urandom_range(1, 255));
         else query_bytes[5] = ($urandom_range(0, 1) != 0) ? 8'h00 : 8'($urandom_range(2, 255));
      end else if (kind < 76) begin
         query_bytes[12] = 8'($urandom_range(MAX_LABEL + 1, 255));
      end else if (kind < 84) begin
         // Flip one bit of type or class.
         spot = query_bytes.size() - 1 - $urandom_range(0, 3);
         query_bytes[spot] ^= 8'(1 << $urandom_range(0, 7));
      end else begin
         // End the packet before the last class byte.
         cut = $urandom_range(1, query_bytes.size() - 1);
         while (query_bytes.size() > cut) void'(query_bytes.pop_back());
      end
   endfunction

   initial begin : stimulus
      int unsigned random_bytes;
      int unsigned phase_no;
      csr_write_enable = 1'b0;
      csr_index        = CSR_IDX_ENABLE;
      csr_write_data   = 32'd0;
      ledger           = new();
      random_bytes     = 0;
      while (reset) @(negedge clock);

      // Responder still disabled after reset: drop the one-byte packet.
      query_bytes = '{8'hFF};
      queue_packet();
      wait_quiet();

      // Enable only, so the shortest legal query returns the reset address.
      write_register(CSR_IDX_ENABLE, 32'd1);
      query_bytes = '{8'hFF, 8'h00, 8'h7F, 8'hFF, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'hFF,
                      8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01};
      queue_packet();
      // Response bit set; the byte after the drop is skipped up to the end.
      query_bytes = '{8'h12, 8'h34, 8'h80, 8'h00};
      queue_packet();

      for (phase_no = 0; random_bytes < 400; phase_no++) begin
         wait_quiet();
         write_register(CSR_IDX_ENABLE,
                        (phase_no < 4 || $urandom_range(0, 4) != 0) ? 32'd1 : 32'd0);
         write_register(CSR_IDX_ADDRESS, (phase_no == 0) ? 32'h0000_0000 :
                                         (phase_no == 1) ? 32'hFFFF_FFFF : $urandom);
         repeat ($urandom_range(2, 5)) begin
            random_query();
            random_bytes += query_bytes.size();
            queue_packet();
         end
      end

      wait_quiet();
      if (ledger.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
`default_nettype wire
